>>> rtl/lps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the line pixel stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

	localparam int unsigned COORD_BITS_DEFAULT = 16;
	localparam int unsigned COLOR_BITS = 32;
	localparam int unsigned MAX_PIXELS = 3;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	typedef enum logic [2:0] {
		MODE_POINT = 3'd0,
		MODE_VERT  = 3'd1,
		MODE_HORZ  = 3'd2,
		MODE_XMAJ  = 3'd3,
		MODE_YMAJ  = 3'd4
	} lps_mode_t;

	// Summary of the pixels that one advance produces.
	typedef struct packed {
		logic [1:0] count;
		logic       done;
	} lps_burst_t;

endpackage

>>> rtl/line_pixel_stepper.sv
`timescale 1ns / 1ps
// A pixel word appears on the master side in the cycle after its advance is taken.
// One pixel word per cycle while m_tready is high; an advance yielding n pixels holds the
// output until all n have left, and the next command is taken in the cycle its last word
// leaves the result register. Loads produce nothing and are taken when it is free.
// Reset (arst_n low) clears the busy flag and the held pixel count; no line is active after it.
// ----------------------------------------------------------------------------
// line_pixel_stepper
// Steps a line between two signed endpoints into stair-connected pixels,
// one to three pixels for each advance command while a line is active.
// ----------------------------------------------------------------------------
module line_pixel_stepper #(
	parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEFAULT,
	localparam int unsigned IN_W  = ((4 * COORD_BITS + lps_pkg::COLOR_BITS + 7) / 8) * 8,
	localparam int unsigned OUT_W = ((2 * COORD_BITS + lps_pkg::COLOR_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// start_x, start_y, end_x, end_y, line_color, zero fill
	input  logic [IN_W-1:0]  s_tdata,
	// opcode
	input  logic             s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// pixel_x, pixel_y, pixel_color, zero fill
	output logic [OUT_W-1:0] m_tdata,
	// last_of_run
	output logic             m_tlast,
	// line_done
	output logic             m_tuser
);

	localparam int unsigned C = COORD_BITS;

	logic                           accept;
	logic                           free;
	logic [C-1:0]                   px [lps_pkg::MAX_PIXELS];
	logic [C-1:0]                   py [lps_pkg::MAX_PIXELS];
	logic [lps_pkg::COLOR_BITS-1:0] color;
	lps_pkg::lps_burst_t            burst;

	assign s_tready = free;
	assign accept   = s_tvalid && s_tready;

	lps_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (s_tuser),
		.start_x   (s_tdata[C-1:0]),
		.start_y   (s_tdata[2*C-1:C]),
		.end_x     (s_tdata[3*C-1:2*C]),
		.end_y     (s_tdata[4*C-1:3*C]),
		.line_color(s_tdata[4*C+lps_pkg::COLOR_BITS-1:4*C]),
		.px        (px),
		.py        (py),
		.color     (color),
		.burst     (burst)
	);

	lps_outbuf #(
		.COORD_BITS(COORD_BITS)
	) u_outbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (accept && burst.count != 2'd0 && s_tuser == lps_pkg::OP_ADVANCE),
		.burst   (burst),
		.px      (px),
		.py      (py),
		.color   (color),
		.free    (free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

endmodule

>>> rtl/lps_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_core
// Line state registers and the single-pass step logic: a load latches the
// endpoints and deltas, an advance yields up to three pixels.
// ----------------------------------------------------------------------------
module lps_core #(
	parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic                            opcode,
	input  logic signed [COORD_BITS-1:0]    start_x,
	input  logic signed [COORD_BITS-1:0]    start_y,
	input  logic signed [COORD_BITS-1:0]    end_x,
	input  logic signed [COORD_BITS-1:0]    end_y,
	input  logic [lps_pkg::COLOR_BITS-1:0]  line_color,
	output logic [COORD_BITS-1:0]           px [lps_pkg::MAX_PIXELS],
	output logic [COORD_BITS-1:0]           py [lps_pkg::MAX_PIXELS],
	output logic [lps_pkg::COLOR_BITS-1:0]  color,
	output lps_pkg::lps_burst_t             burst
);

	localparam int unsigned D = COORD_BITS + 1;

	logic                          busy_q;
	lps_pkg::lps_mode_t            mode_q;
	logic [COORD_BITS-1:0]         cur_x_q, cur_y_q, stop_x_q, stop_y_q;
	logic [D-1:0]                  acc_q, major_q, minor_q;
	logic                          sign_q;
	logic [lps_pkg::COLOR_BITS-1:0] color_q;

	// load decode
	logic signed [D-1:0]   dxs, dys;
	logic [D-1:0]          dx, dy;
	logic                  dx_neg, dy_neg, swap;
	lps_pkg::lps_mode_t    ld_mode;
	logic                  ld_sign;

	// advance
	logic [D-1:0]          acc_sum, acc_next;
	logic                  minor_step, at_stop;
	logic [COORD_BITS-1:0] x1, y1, nx, ny;
	logic                  adv_busy;

	function automatic logic [COORD_BITS-1:0] step_toward(
		input logic [COORD_BITS-1:0] v,
		input logic                  neg
	);
		return neg ? v - COORD_BITS'(1) : v + COORD_BITS'(1);
	endfunction

	always_comb begin
		dxs    = D'(end_x) - D'(start_x);
		dys    = D'(end_y) - D'(start_y);
		dx_neg = dxs[D-1];
		dy_neg = dys[D-1];
		dx     = dx_neg ? -dxs : dxs;
		dy     = dy_neg ? -dys : dys;
		swap   = 1'b0;
		if (dx == '0 && dy == '0) begin
			ld_mode = lps_pkg::MODE_POINT;
			ld_sign = 1'b0;
		end else if (dx == '0) begin
			ld_mode = lps_pkg::MODE_VERT;
			ld_sign = dy_neg;
		end else if (dy == '0) begin
			ld_mode = lps_pkg::MODE_HORZ;
			ld_sign = dx_neg;
		end else if (dx >= dy) begin
			ld_mode = lps_pkg::MODE_XMAJ;
			swap    = dx_neg;
			ld_sign = dy_neg ^ dx_neg;
		end else begin
			ld_mode = lps_pkg::MODE_YMAJ;
			swap    = dy_neg;
			ld_sign = dx_neg ^ dy_neg;
		end
	end

	always_comb begin
		acc_sum    = acc_q + minor_q;
		minor_step = 1'b0;
		acc_next   = acc_q;
		at_stop    = 1'b0;
		x1         = cur_x_q;
		y1         = cur_y_q;
		nx         = cur_x_q;
		ny         = cur_y_q;
		adv_busy   = accept && opcode == lps_pkg::OP_ADVANCE && busy_q;
		px[0]      = cur_x_q;
		py[0]      = cur_y_q;
		px[1]      = stop_x_q;
		py[1]      = stop_y_q;
		px[2]      = stop_x_q;
		py[2]      = stop_y_q;
		burst      = '{count: 2'd0, done: 1'b0};
		unique case (mode_q) inside
			lps_pkg::MODE_POINT: begin
				burst = '{count: 2'd1, done: 1'b1};
			end
			lps_pkg::MODE_VERT, lps_pkg::MODE_HORZ: begin
				at_stop = cur_x_q == stop_x_q && cur_y_q == stop_y_q;
				burst   = '{count: 2'd1, done: at_stop};
				if (!at_stop) begin
					if (mode_q == lps_pkg::MODE_VERT) begin
						ny = step_toward(cur_y_q, sign_q);
					end else begin
						nx = step_toward(cur_x_q, sign_q);
					end
				end
			end
			lps_pkg::MODE_XMAJ, lps_pkg::MODE_YMAJ: begin
				minor_step = acc_sum >= major_q;
				acc_next   = minor_step ? acc_sum - major_q : acc_sum;
				if (minor_step) begin
					if (mode_q == lps_pkg::MODE_XMAJ) begin
						y1 = step_toward(cur_y_q, sign_q);
					end else begin
						x1 = step_toward(cur_x_q, sign_q);
					end
				end
				at_stop = (mode_q == lps_pkg::MODE_XMAJ) ? (x1 == stop_x_q) : (y1 == stop_y_q);
				if (minor_step) begin
					px[1] = x1;
					py[1] = y1;
				end
				burst = '{count: 2'd1 + 2'(minor_step) + 2'(at_stop), done: at_stop};
				nx    = x1;
				ny    = y1;
				if (!at_stop) begin
					if (mode_q == lps_pkg::MODE_XMAJ) begin
						nx = step_toward(x1, 1'b0);
					end else begin
						ny = step_toward(y1, 1'b0);
					end
				end
			end
			default: begin
				burst = '{count: 2'd1, done: 1'b1};
			end
		endcase
		if (!busy_q) begin
			burst = '{count: 2'd0, done: 1'b0};
		end
		color = color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= lps_pkg::MODE_POINT;
		end else if (accept && opcode == lps_pkg::OP_LOAD) begin
			busy_q <= 1'b1;
			mode_q <= ld_mode;
		end else if (adv_busy && burst.done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == lps_pkg::OP_LOAD) begin
			color_q  <= line_color;
			sign_q   <= ld_sign;
			acc_q    <= '0;
			cur_x_q  <= swap ? end_x : start_x;
			cur_y_q  <= swap ? end_y : start_y;
			stop_x_q <= swap ? start_x : end_x;
			stop_y_q <= swap ? start_y : end_y;
			if (ld_mode == lps_pkg::MODE_XMAJ) begin
				major_q <= dx;
				minor_q <= dy;
			end else if (ld_mode == lps_pkg::MODE_YMAJ) begin
				major_q <= dy;
				minor_q <= dx;
			end else begin
				major_q <= '0;
				minor_q <= '0;
			end
		end else if (adv_busy) begin
			acc_q   <= acc_next;
			cur_x_q <= nx;
			cur_y_q <= ny;
		end
	end

endmodule

>>> rtl/lps_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lps_outbuf
// Result register for one burst of up to three pixels, shifted out one
// word per cycle on the master side while m_tready is high.
// ----------------------------------------------------------------------------
module lps_outbuf #(
	parameter int unsigned COORD_BITS = lps_pkg::COORD_BITS_DEFAULT,
	localparam int unsigned OUT_RAW = 2 * COORD_BITS + lps_pkg::COLOR_BITS,
	localparam int unsigned OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  lps_pkg::lps_burst_t             burst,
	input  logic [COORD_BITS-1:0]           px [lps_pkg::MAX_PIXELS],
	input  logic [COORD_BITS-1:0]           py [lps_pkg::MAX_PIXELS],
	input  logic [lps_pkg::COLOR_BITS-1:0]  color,
	output logic                            free,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pixel_x, pixel_y, pixel_color, zero fill
	output logic [OUT_W-1:0]                m_tdata,
	output logic                            m_tlast,
	// line_done
	output logic                            m_tuser
);

	logic [1:0]                     cnt_q;
	logic                           done_q;
	logic [COORD_BITS-1:0]          x_q [lps_pkg::MAX_PIXELS];
	logic [COORD_BITS-1:0]          y_q [lps_pkg::MAX_PIXELS];
	logic [lps_pkg::COLOR_BITS-1:0] color_q;
	logic                           pop;

	assign m_tvalid = cnt_q != 2'd0;
	assign pop      = m_tvalid && m_tready;
	// A new burst may land once the word now leaving is the last one held.
	assign free     = cnt_q == 2'd0 || (cnt_q == 2'd1 && m_tready);
	assign m_tdata  = OUT_W'({color_q, y_q[0], x_q[0]});
	assign m_tlast  = cnt_q == 2'd1;
	assign m_tuser  = cnt_q == 2'd1 && done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			done_q <= 1'b0;
		end else if (push) begin
			cnt_q  <= burst.count;
			done_q <= burst.done;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			x_q     <= px;
			y_q     <= py;
			color_q <= color;
		end else if (pop) begin
			x_q[0] <= x_q[1];
			y_q[0] <= y_q[1];
			x_q[1] <= x_q[2];
			y_q[1] <= y_q[2];
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> free)
		else $error("burst pushed while earlier pixels still held");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> cnt_q == $past(burst.count))
		else $error("held pixel count does not match pushed burst");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 2'd1)
		else $error("pixel count did not drop after a word left");

	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> burst.count != 2'd0)
		else $error("empty burst pushed");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_pixel_stepper. A driver feeds load and advance
// commands from a queue, a line tracer predicts the pixels of each accepted
// command, and a monitor compares every pixel word leaving the block with the
// oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned CW    = lps_pkg::COORD_BITS_DEFAULT;
	localparam int unsigned IN_W  = ((4 * CW + lps_pkg::COLOR_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_W = ((2 * CW + lps_pkg::COLOR_BITS + 7) / 8) * 8;
	localparam int CMAX = 2 ** (CW - 1) - 1;
	localparam int CMIN = -(2 ** (CW - 1));

	typedef struct {
		logic            op;
		logic [IN_W-1:0] data;
	} line_cmd_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [lps_pkg::COLOR_BITS-1:0] color;
		logic run_end;
		logic line_end;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tuser = lps_pkg::OP_LOAD;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic m_tlast;
	logic m_tuser;

	line_cmd_t line_cmds[$];
	pixel_t expected_pixels[$];
	logic s_taken = 1'b0;
	int unsigned cyc = 0;
	int errors = 0;

	// Tracer state, mirroring the block after reset.
	logic line_busy = 1'b0;
	lps_pkg::lps_mode_t line_mode = lps_pkg::MODE_POINT;
	logic signed [CW-1:0] pos_x = '0, pos_y = '0, tgt_x = '0, tgt_y = '0;
	int acc = 0, dmaj = 0, dmin = 0;
	logic neg_step = 1'b0;
	logic [lps_pkg::COLOR_BITS-1:0] line_color = '0;

	line_pixel_stepper #(.COORD_BITS(CW)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	function automatic pixel_t make_pixel(input logic signed [CW-1:0] x, y);
		pixel_t p;
		p.x = x;
		p.y = y;
		p.color = line_color;
		p.run_end = 1'b0;
		p.line_end = 1'b0;
		return p;
	endfunction

	function automatic void latch_line(input logic [IN_W-1:0] d);
		int x1, y1, x2, y2, dx, dy, t;
		logic swap;
		x1 = $signed(d[CW-1:0]);
		y1 = $signed(d[2*CW-1:CW]);
		x2 = $signed(d[3*CW-1:2*CW]);
		y2 = $signed(d[4*CW-1:3*CW]);
		dx = (x1 < x2) ? x2 - x1 : x1 - x2;
		dy = (y1 < y2) ? y2 - y1 : y1 - y2;
		swap = 1'b0;
		line_color = d[4*CW+lps_pkg::COLOR_BITS-1:4*CW];
		line_busy = 1'b1;
		acc = 0;
		if (dx == 0 && dy == 0) begin
			line_mode = lps_pkg::MODE_POINT;
			neg_step = 1'b0;
		end else if (dx == 0) begin
			line_mode = lps_pkg::MODE_VERT;
			neg_step = y2 < y1;
		end else if (dy == 0) begin
			line_mode = lps_pkg::MODE_HORZ;
			neg_step = x2 < x1;
		end else if (dx >= dy) begin
			line_mode = lps_pkg::MODE_XMAJ;
			swap = x2 < x1;
		end else begin
			line_mode = lps_pkg::MODE_YMAJ;
			swap = y2 < y1;
		end
		// Diagonal lines always walk the major axis upwards.
		if (swap) begin
			t = x1; x1 = x2; x2 = t;
			t = y1; y1 = y2; y2 = t;
		end
		pos_x = x1[CW-1:0];
		pos_y = y1[CW-1:0];
		tgt_x = x2[CW-1:0];
		tgt_y = y2[CW-1:0];
		if (line_mode == lps_pkg::MODE_XMAJ) begin
			dmaj = dx; dmin = dy; neg_step = y2 < y1;
		end else if (line_mode == lps_pkg::MODE_YMAJ) begin
			dmaj = dy; dmin = dx; neg_step = x2 < x1;
		end else begin
			dmaj = 0; dmin = 0;
		end
	endfunction

	function automatic void trace_line_step(input logic op, input logic [IN_W-1:0] d);
		pixel_t burst[$];
		logic done;
		done = 1'b0;
		if (op == lps_pkg::OP_LOAD) begin
			latch_line(d);
			return;
		end
		if (!line_busy)
			return;
		burst.push_back(make_pixel(pos_x, pos_y));
		if (line_mode == lps_pkg::MODE_VERT || line_mode == lps_pkg::MODE_HORZ) begin
			if (pos_x == tgt_x && pos_y == tgt_y)
				done = 1'b1;
			else if (line_mode == lps_pkg::MODE_VERT)
				pos_y = neg_step ? pos_y - 1'b1 : pos_y + 1'b1;
			else
				pos_x = neg_step ? pos_x - 1'b1 : pos_x + 1'b1;
		end else if (line_mode == lps_pkg::MODE_XMAJ || line_mode == lps_pkg::MODE_YMAJ) begin
			acc += dmin;
			if (acc >= dmaj) begin
				acc -= dmaj;
				if (line_mode == lps_pkg::MODE_XMAJ)
					pos_y = neg_step ? pos_y - 1'b1 : pos_y + 1'b1;
				else
					pos_x = neg_step ? pos_x - 1'b1 : pos_x + 1'b1;
				burst.push_back(make_pixel(pos_x, pos_y));
			end
			if (line_mode == lps_pkg::MODE_XMAJ ? (pos_x == tgt_x) : (pos_y == tgt_y)) begin
				burst.push_back(make_pixel(tgt_x, tgt_y));
				done = 1'b1;
			end else if (line_mode == lps_pkg::MODE_XMAJ) begin
				pos_x = pos_x + 1'b1;
			end else begin
				pos_y = pos_y + 1'b1;
			end
		end else begin
			done = 1'b1;
		end
		burst[burst.size()-1].run_end = 1'b1;
		if (done) begin
			burst[burst.size()-1].line_end = 1'b1;
			line_busy = 1'b0;
		end
		foreach (burst[i])
			expected_pixels.push_back(burst[i]);
	endfunction

	task automatic queue_load(input int x1, y1, x2, y2,
			input logic [lps_pkg::COLOR_BITS-1:0] col);
		line_cmd_t c;
		c.op = lps_pkg::OP_LOAD;
		c.data = {col, y2[CW-1:0], x2[CW-1:0], y1[CW-1:0], x1[CW-1:0]};
		line_cmds.push_back(c);
	endtask

	// Advance words carry junk in the data field, which the block must ignore.
	task automatic queue_advances(input int n);
		line_cmd_t c;
		c.op = lps_pkg::OP_ADVANCE;
		repeat (n) begin
			c.data = {$urandom, $urandom, $urandom};
			line_cmds.push_back(c);
		end
	endtask

	function automatic int rand_coord();
		logic signed [CW-1:0] v;
		v = CW'($urandom);
		return int'(v);
	endfunction

	function automatic int far_end(input int from, input int span);
		int d;
		d = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, span);
		if ($urandom_range(0, 1) == 1)
			d = -d;
		if (from + d > CMAX || from + d < CMIN)
			d = -d;
		return from + d;
	endfunction

	task automatic queue_random_line(input int span, output int steps);
		int x1, y1, x2, y2, dx, dy;
		x1 = rand_coord();
		y1 = rand_coord();
		x2 = far_end(x1, span);
		y2 = far_end(y1, span);
		dx = (x2 > x1) ? x2 - x1 : x1 - x2;
		dy = (y2 > y1) ? y2 - y1 : y1 - y2;
		steps = ((dx > dy) ? dx : dy) + 1;
		queue_load(x1, y1, x2, y2, $urandom);
	endtask

	// Driver: presents the next command once the current one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_taken)) begin
			if (line_cmds.size() != 0 &&
					(cyc >= 150 && cyc < 450 || $urandom_range(0, 99) >= 8)) begin
				s_tvalid <= 1'b1;
				s_tuser <= line_cmds[0].op;
				s_tdata <= line_cmds[0].data;
				void'(line_cmds.pop_front());
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		if (arst_n)
			m_tready <= (cyc >= 150 && cyc < 450) || $urandom_range(0, 99) >= 8;
	end

	// Monitor: predicts on every accepted command and checks every pixel word.
	always @(posedge clk) begin
		pixel_t exp_px;
		cyc <= cyc + 1;
		s_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				trace_line_step(s_tuser, s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					$display("%0t: unexpected pixel word x=%0d y=%0d color=%h last=%b done=%b",
						$time, $signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]),
						m_tdata[2*CW+lps_pkg::COLOR_BITS-1:2*CW], m_tlast, m_tuser);
				end else begin
					exp_px = expected_pixels.pop_front();
					if (m_tdata[CW-1:0] !== exp_px.x || m_tdata[2*CW-1:CW] !== exp_px.y ||
							m_tdata[2*CW+lps_pkg::COLOR_BITS-1:2*CW] !== exp_px.color ||
							m_tlast !== exp_px.run_end || m_tuser !== exp_px.line_end) begin
						errors++;
						$display("%0t: expected x=%0d y=%0d color=%h last=%b done=%b",
							$time, exp_px.x, exp_px.y, exp_px.color, exp_px.run_end,
							exp_px.line_end);
						$display("%0t: actual   x=%0d y=%0d color=%h last=%b done=%b",
							$time, $signed(m_tdata[CW-1:0]), $signed(m_tdata[2*CW-1:CW]),
							m_tdata[2*CW+lps_pkg::COLOR_BITS-1:2*CW], m_tlast, m_tuser);
					end
				end
			end
		end
	end

	initial begin
		int steps, pick, r;
		// Directed part: idle advance, every line kind, the overshoot on equal
		// deltas at the coordinate limit, and a long line replaced mid-way.
		queue_advances(1);
		queue_load(CMAX, CMIN, CMAX, CMIN, 32'hFFFF_FFFF);
		queue_advances(2);
		queue_load(CMIN, 2, CMIN, 0, 32'h1234_5678);
		queue_advances(3);
		queue_load(1, -5, -1, -5, 32'h8000_0001);
		queue_advances(3);
		queue_load(CMAX - 1, CMAX - 1, CMAX, CMAX, 32'hA5A5_5A5A);
		queue_advances(2);
		queue_load(0, 3, -1, 0, 32'h0F0F_F0F0);
		queue_advances(4);
		queue_load(CMIN, CMIN, CMAX, CMAX, 32'hDEAD_BEEF);
		queue_advances(2);
		queue_load(CMAX, CMAX, CMAX, CMAX, 32'h0000_0000);
		queue_advances(1);

		// Random part: mostly whole lines, some cut short or overrun, plus noise.
		while (line_cmds.size() < 272) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				queue_random_line(($urandom_range(0, 9) == 0) ? 40 : 6, steps);
				r = $urandom_range(0, 9);
				if (r == 0)
					queue_advances($urandom_range(0, steps - 1));
				else if (r == 1)
					queue_advances(steps + $urandom_range(1, 3));
				else
					queue_advances(steps);
			end else if (pick < 90) begin
				queue_advances($urandom_range(1, 3));
			end else begin
				queue_load(rand_coord(), rand_coord(), rand_coord(), rand_coord(), $urandom);
				queue_advances($urandom_range(0, 4));
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (line_cmds.size() != 0 || s_tvalid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

endmodule
